>>> design/ptpt_pkg.sv
// Shared types and constants of the per-node traffic policer table.
package ptpt_pkg;

    localparam int NODE_W    = 8;
    localparam int TRAFFIC_W = 16;
    localparam int WARN_W    = 4;
    localparam int KIDS_W    = 7;
    localparam int STATUS_W  = 3;
    localparam int REGCNT_W  = 6;

    // Threshold polynomial scaled by 10000:
    // T10k(n) = C0 + C1 n - C2 n^2 + C3 n^3, with n = child_count + 1
    localparam int THR_C0 = 2950;
    localparam int THR_C1 = 29400;
    localparam int THR_C2 = 560;
    localparam int THR_C3 = 6;
    localparam int SCALE  = 10000;

    localparam int N_W    = 8;   // child_count + 1, up to 128
    localparam int SQ_W   = 15;  // 128^2 = 2^14 needs 15 bits
    localparam int CUBE_W = 22;  // 128^3 = 2^21 needs 22 bits
    localparam int LIN_W  = 22;
    localparam int THR_W  = 32;
    localparam int PROD_W = 30;  // 65535 * 10000 fits

    // APB register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_WARN_LIMIT = 1'b0;  // word index, paddr[2]
    localparam logic [WARN_W-1:0] WARN_LIMIT_RST = 4'd3;

    // Function codes
    localparam logic [1:0] FUNC_REPORT = 2'd0;
    localparam logic [1:0] FUNC_UNMUTE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_WITHIN  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_WARNED  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_PENALTY = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL    = 3'd4;
    localparam logic [STATUS_W-1:0] STS_ID_ZERO = 3'd5;
    localparam logic [STATUS_W-1:0] STS_DONE    = 3'd6;

    typedef struct packed {
        logic [1:0]        func;
        logic [NODE_W-1:0] node_id;
        logic [KIDS_W-1:0] child_count;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                penalized;
        logic                node_muted;
        logic [REGCNT_W-1:0] registered_children;
    } t_result;

    typedef struct packed {
        logic [WARN_W-1:0]    warn;
        logic [TRAFFIC_W-1:0] traffic;
    } t_cnt;

    // Which result the datapath captures at the end of an item
    typedef enum logic [2:0] {
        SEL_ID_ZERO,
        SEL_FULL,
        SEL_ADDED,
        SEL_DONE_CLR,
        SEL_DONE_MUTE,
        SEL_POLICE
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     addr_clr;
        logic     scan_run;
        logic     sweep_run;
        logic     cnt_rd;
        logic     cnt_inc;
        logic     decide;
        logic     alloc;
        logic     unmute;
        logic     res_load;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       id_zero;
        logic       hit;
        logic       miss;
        logic       full;
        logic       swp_done;
    } t_sts;

endpackage

>>> design/per_node_traffic_policer_table_unit.sv
// Top level of the per-node traffic policer table with its APB register port.
//
// Keeps up to TABLE_ENTRIES child nodes, each with a traffic count, a warning
// count and a mute flag. Raise start for one cycle with an item while busy is
// low; the item is taken at that edge and busy rises on the next cycle. Exactly
// one result beat follows, shown on o_result for a single cycle with o_strobe
// high. The receiver cannot stall this beat, so it must capture it on that
// edge. The node search reads the node memory one entry per cycle, over the
// allocated entries only (at most TABLE_ENTRIES). A period tick first sweeps
// the count memory, one entry per cycle. No clearing pass is needed after
// reset: only allocated entries are ever searched, and allocation writes every
// field of its entry. The threshold 0.295 + 2.94 n - 0.056 n^2 + 0.0006 n^3
// is evaluated exactly as an integer scaled by 10000 in a three-stage pipeline
// that settles while the search runs. Write warning_limit (byte address 0)
// only while busy is low.
module per_node_traffic_policer_table_unit #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  ptpt_pkg::t_item               i_item,
    // result channel
    output logic                          o_strobe,
    output ptpt_pkg::t_result             o_result,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptpt_pkg::APB_AW-1:0]   paddr,
    input  logic [ptpt_pkg::APB_DW-1:0]   pwdata,
    output logic [ptpt_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [ptpt_pkg::WARN_W-1:0] r_warn_limit;
    logic                        reg_sel;
    logic                        cfg_wr;
    ptpt_pkg::t_cmd              cmd;
    ptpt_pkg::t_sts              sts;

    // Single register: word index lives in paddr[2], byte offset is ignored
    assign reg_sel = (paddr[2] == ptpt_pkg::REG_WARN_LIMIT);
    assign cfg_wr  = psel && penable && pwrite && reg_sel;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? ptpt_pkg::APB_DW'(r_warn_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_limit <= ptpt_pkg::WARN_LIMIT_RST;
        end else if (cfg_wr) begin
            r_warn_limit <= pwdata[ptpt_pkg::WARN_W-1:0];
        end
    end

    // Controller: sequences each item and drives busy
    ptpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath: entry memories, search, threshold and result registers
    ptpt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_warn_limit (r_warn_limit),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_result     (o_result),
        .o_strobe     (o_strobe)
    );

endmodule

>>> design/ptpt_dp.sv
// Datapath of the policer table: entry memories, search, threshold and result registers.
module ptpt_dp #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptpt_pkg::t_item   i_item,
    input  logic [ptpt_pkg::WARN_W-1:0] i_warn_limit,
    input  ptpt_pkg::t_cmd    i_cmd,
    output ptpt_pkg::t_sts    o_sts,
    output ptpt_pkg::t_result o_result,
    output logic              o_strobe
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    // Entry memories
    logic [ptpt_pkg::NODE_W-1:0] r_node_mem [TABLE_ENTRIES];
    ptpt_pkg::t_cnt              r_cnt_mem  [TABLE_ENTRIES];
    logic                        r_mute_mem [TABLE_ENTRIES];

    // Latched item
    logic [1:0]                  r_func;
    logic [ptpt_pkg::NODE_W-1:0] r_id;
    logic [ptpt_pkg::N_W-1:0]    r_n;

    // Threshold pipeline
    logic [ptpt_pkg::SQ_W-1:0]   r_sq;
    logic [ptpt_pkg::CUBE_W-1:0] r_cube;
    logic [ptpt_pkg::LIN_W-1:0]  r_lin;
    logic [ptpt_pkg::THR_W-1:0]  r_thr;

    // Search and sweep
    logic [CNT_W-1:0]            r_alloc;
    logic [CNT_W-1:0]            r_addr;
    logic                        r_rd_vld;
    logic [IDX_W-1:0]            r_rd_idx;
    logic [ptpt_pkg::NODE_W-1:0] r_node_q;
    logic                        r_hit;
    logic                        r_miss;
    logic                        r_swp_done;
    logic [IDX_W-1:0]            r_idx;

    // Count update
    ptpt_pkg::t_cnt                 r_cnt_q;
    logic                           r_mute_q;
    logic [ptpt_pkg::TRAFFIC_W-1:0] r_traffic_new;
    logic [ptpt_pkg::PROD_W-1:0]    r_prod;
    logic [ptpt_pkg::STATUS_W-1:0]  r_pol_status;
    logic                           r_pol_pen;
    logic                           r_pol_muted;

    ptpt_pkg::t_result r_result;
    logic              r_strobe;

    logic                           issue;
    logic                           match;
    logic [ptpt_pkg::TRAFFIC_W-1:0] traffic_inc;
    logic                           over;
    logic [ptpt_pkg::WARN_W:0]      warn_inc;
    logic                           pen;

    logic                        node_we;
    logic                        cnt_we;
    logic [IDX_W-1:0]            cnt_wa;
    ptpt_pkg::t_cnt              cnt_wd;
    logic                        mute_we;
    logic [IDX_W-1:0]            mute_wa;
    logic                        mute_wd;

    assign issue = (r_addr < r_alloc);
    assign match = r_rd_vld && (r_node_q == r_id);

    assign traffic_inc = (r_cnt_q.traffic == {ptpt_pkg::TRAFFIC_W{1'b1}}) ?
                         r_cnt_q.traffic : r_cnt_q.traffic + 16'd1;
    assign over        = ptpt_pkg::THR_W'(r_prod) > r_thr;
    assign warn_inc    = {1'b0, r_cnt_q.warn} + 5'd1;
    assign pen         = over && (warn_inc > {1'b0, i_warn_limit});

    // Write port selection
    always_comb begin
        node_we = i_cmd.alloc;
        cnt_we  = 1'b0;
        cnt_wa  = r_idx;
        cnt_wd  = '0;
        if (i_cmd.alloc) begin
            cnt_we         = 1'b1;
            cnt_wa         = r_alloc[IDX_W-1:0];
            cnt_wd.traffic = 16'd1;
        end else if (i_cmd.sweep_run && !r_swp_done && issue) begin
            cnt_we = 1'b1;
            cnt_wa = r_addr[IDX_W-1:0];
        end else if (i_cmd.decide) begin
            cnt_we = 1'b1;
            if (pen) begin
                cnt_wd = '0;
            end else if (over) begin
                cnt_wd.warn = warn_inc[ptpt_pkg::WARN_W-1:0];
            end else begin
                cnt_wd.warn    = r_cnt_q.warn;
                cnt_wd.traffic = r_traffic_new;
            end
        end
    end

    always_comb begin
        mute_we = 1'b0;
        mute_wa = r_idx;
        mute_wd = 1'b0;
        if (i_cmd.alloc) begin
            mute_we = 1'b1;
            mute_wa = r_alloc[IDX_W-1:0];
        end else if (i_cmd.unmute) begin
            mute_we = 1'b1;
        end else if (i_cmd.decide && pen) begin
            mute_we = 1'b1;
            mute_wd = 1'b1;
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[r_alloc[IDX_W-1:0]] <= r_id;
        end
        if (i_cmd.scan_run && issue) begin
            r_node_q <= r_node_mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= r_cnt_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mute_we) begin
            r_mute_mem[mute_wa] <= mute_wd;
        end
        if (i_cmd.cnt_rd) begin
            r_mute_q <= r_mute_mem[r_idx];
        end
    end

    // Item capture and threshold pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_item.func;
            r_id   <= i_item.node_id;
            r_n    <= ptpt_pkg::N_W'(i_item.child_count) + 8'd1;
        end
        r_sq   <= ptpt_pkg::SQ_W'(r_n) * ptpt_pkg::SQ_W'(r_n);
        r_lin  <= ptpt_pkg::LIN_W'(ptpt_pkg::THR_C1) * ptpt_pkg::LIN_W'(r_n)
                  + ptpt_pkg::LIN_W'(ptpt_pkg::THR_C0);
        r_cube <= ptpt_pkg::CUBE_W'(r_sq) * ptpt_pkg::CUBE_W'(r_n);
        r_thr  <= ptpt_pkg::THR_W'(r_lin)
                  + ptpt_pkg::THR_W'(r_cube) * ptpt_pkg::THR_W'(ptpt_pkg::THR_C3)
                  - ptpt_pkg::THR_W'(r_sq) * ptpt_pkg::THR_W'(ptpt_pkg::THR_C2);
    end

    // Search and sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_miss     <= 1'b0;
            r_swp_done <= 1'b0;
            r_alloc    <= '0;
        end else begin
            if (i_cmd.addr_clr) begin
                r_addr     <= '0;
                r_rd_vld   <= 1'b0;
                r_hit      <= 1'b0;
                r_miss     <= 1'b0;
                r_swp_done <= 1'b0;
            end else if (i_cmd.scan_run && !r_hit && !r_miss) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (match) begin
                    r_hit <= 1'b1;
                end else if (!issue) begin
                    r_miss <= 1'b1;
                end
            end else if (i_cmd.sweep_run && !r_swp_done) begin
                if (issue) begin
                    r_addr <= r_addr + 1'b1;
                end else begin
                    r_swp_done <= 1'b1;
                end
            end
            if (i_cmd.alloc) begin
                r_alloc <= r_alloc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && !r_hit && !r_miss) begin
            if (issue) begin
                r_rd_idx <= r_addr[IDX_W-1:0];
            end
            if (match) begin
                r_idx <= r_rd_idx;
            end
        end
    end

    // Count update and policing decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_inc) begin
            r_traffic_new <= traffic_inc;
            r_prod        <= ptpt_pkg::PROD_W'(traffic_inc) * ptpt_pkg::PROD_W'(ptpt_pkg::SCALE);
        end
        if (i_cmd.decide) begin
            r_pol_pen <= pen;
            if (pen) begin
                r_pol_status <= ptpt_pkg::STS_PENALTY;
                r_pol_muted  <= 1'b1;
            end else if (over) begin
                r_pol_status <= ptpt_pkg::STS_WARNED;
                r_pol_muted  <= r_mute_q;
            end else begin
                r_pol_status <= ptpt_pkg::STS_WITHIN;
                r_pol_muted  <= r_mute_q;
            end
        end
    end

    // Result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result.registered_children <= ptpt_pkg::REGCNT_W'(r_alloc);
            r_result.penalized           <= 1'b0;
            r_result.node_muted          <= 1'b0;
            case (i_cmd.res_sel)
                ptpt_pkg::SEL_ID_ZERO:   r_result.status <= ptpt_pkg::STS_ID_ZERO;
                ptpt_pkg::SEL_FULL:      r_result.status <= ptpt_pkg::STS_FULL;
                ptpt_pkg::SEL_ADDED:     r_result.status <= ptpt_pkg::STS_ADDED;
                ptpt_pkg::SEL_DONE_MUTE: begin
                    r_result.status     <= ptpt_pkg::STS_DONE;
                    r_result.node_muted <= r_mute_q;
                end
                ptpt_pkg::SEL_POLICE: begin
                    r_result.status     <= r_pol_status;
                    r_result.penalized  <= r_pol_pen;
                    r_result.node_muted <= r_pol_muted;
                end
                default:                 r_result.status <= ptpt_pkg::STS_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.res_load;
        end
    end

    assign o_sts.func     = r_func;
    assign o_sts.id_zero  = (r_id == '0);
    assign o_sts.hit      = r_hit;
    assign o_sts.miss     = r_miss;
    assign o_sts.full     = (r_alloc == CNT_FULL);
    assign o_sts.swp_done = r_swp_done;

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule

>>> design/ptpt_ctrl.sv
// Controller of the policer table: sequences lookup, allocation, policing, unmute and sweep.
module ptpt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ptpt_pkg::t_sts i_sts,
    output ptpt_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SWEEP,
        S_SCAN,
        S_CNT_RD,
        S_CNT_INC,
        S_DECIDE,
        S_ALLOC,
        S_UNMUTE,
        S_MUTE_RD,
        S_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic               r_busy;
    ptpt_pkg::t_res_sel r_sel, n_sel;

    logic access_fn;

    assign access_fn = (i_sts.func == ptpt_pkg::FUNC_REPORT) ||
                       (i_sts.func == ptpt_pkg::FUNC_UNMUTE);

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.res_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.addr_clr = 1'b1;
                if (access_fn && i_sts.id_zero) begin
                    n_sel   = ptpt_pkg::SEL_ID_ZERO;
                    n_state = S_FINISH;
                end else if (i_sts.func == ptpt_pkg::FUNC_TICK) begin
                    n_state = S_SWEEP;
                end else if (i_sts.id_zero) begin
                    n_sel   = ptpt_pkg::SEL_DONE_CLR;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_sts.swp_done) begin
                    if (i_sts.id_zero) begin
                        n_sel   = ptpt_pkg::SEL_DONE_CLR;
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.addr_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.hit) begin
                    if (i_sts.func == ptpt_pkg::FUNC_REPORT) begin
                        n_state = S_CNT_RD;
                    end else if (i_sts.func == ptpt_pkg::FUNC_UNMUTE) begin
                        n_state = S_UNMUTE;
                    end else begin
                        n_state = S_MUTE_RD;
                    end
                end else if (i_sts.miss) begin
                    if (i_sts.func != ptpt_pkg::FUNC_REPORT) begin
                        n_sel   = ptpt_pkg::SEL_DONE_CLR;
                        n_state = S_FINISH;
                    end else if (i_sts.full) begin
                        n_sel   = ptpt_pkg::SEL_FULL;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_INC;
            end
            S_CNT_INC: begin
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_sel        = ptpt_pkg::SEL_POLICE;
                n_state      = S_FINISH;
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_sel       = ptpt_pkg::SEL_ADDED;
                n_state     = S_FINISH;
            end
            S_UNMUTE: begin
                o_cmd.unmute = 1'b1;
                n_sel        = ptpt_pkg::SEL_DONE_CLR;
                n_state      = S_FINISH;
            end
            S_MUTE_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_sel        = ptpt_pkg::SEL_DONE_MUTE;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.res_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_sel   <= ptpt_pkg::SEL_DONE_CLR;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_sel   <= n_sel;
        end
    end

    assign o_busy = r_busy;

endmodule
